[src/nsrh_pkg.sv]
// Package: types, constants and codes for the nearest segment ray hit block.
package nsrh_pkg;

  localparam int MaxSegments = 16;
  localparam int SlotW       = 4;
  localparam int CountW      = 5;
  localparam int CfgIndexW   = 4;
  localparam int CfgDataW    = 16;
  localparam int DivSteps    = 17;   // quotient bits, t in [0, 1.0] with 1.0 = 65536
  localparam int RootSteps   = 17;
  localparam int RemW        = 36;
  localparam int MagW        = 35;
  localparam logic signed [34:0] CollinearEps = 35'sd7;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  localparam logic [CfgIndexW-1:0] CFG_RANGE_LIMIT   = 4'd0;
  localparam logic [CfgIndexW-1:0] CFG_SEGMENT_COUNT = 4'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ROOT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              operation;
    logic [SlotW-1:0]  slot;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
  } command_t;

  typedef struct packed {
    logic              hit;
    logic [15:0]       distance;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
  } result_t;

  typedef struct packed {
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic signed [15:0] x2;
    logic signed [15:0] y2;
  } segment_t;

  // One slot of the divider chain.
  typedef struct packed {
    logic                valid;
    logic                pass;
    logic [RemW-1:0]     rem;
    logic [MagW-1:0]     ad;
    logic [DivSteps-1:0] q;
  } div_lane_t;

endpackage

[src/nsrh_div_cell.sv]
// One restoring-division cell: one quotient bit per cycle, hands its lane to the next cell.
module nsrh_div_cell (
  input  logic              clk,
  input  logic              rst,
  input  nsrh_pkg::div_lane_t lane_in,
  output nsrh_pkg::div_lane_t lane_out
);
  import nsrh_pkg::*;

  logic [RemW:0] diff;
  logic          ge;

  assign diff = {1'b0, lane_in.rem} - {2'b00, lane_in.ad};
  assign ge   = ~diff[RemW];

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_out.valid <= 1'b0;
    end else begin
      lane_out.valid <= lane_in.valid;
    end
    lane_out.pass <= lane_in.pass;
    lane_out.ad   <= lane_in.ad;
    lane_out.q    <= {lane_in.q[DivSteps-2:0], ge};
    // remainder stays below ad, so the shift never loses a bit
    lane_out.rem  <= ge ? {diff[RemW-2:0], 1'b0} : {lane_in.rem[RemW-2:0], 1'b0};
  end

endmodule

[src/nsrh_sqrt.sv]
// Iterative integer square root, one result bit per cycle.
module nsrh_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [33:0] value,
  output logic        done,
  output logic [17:0] root
);
  import nsrh_pkg::*;

  logic [33:0] v;
  logic [33:0] r;
  logic [33:0] b;
  logic [4:0]  cnt;
  logic [33:0] trial;

  assign trial = r + b;
  assign root  = r[17:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == 5'd1);
      if (go) begin
        cnt <= 5'(RootSteps);
      end else if (cnt != '0) begin
        cnt <= cnt - 5'd1;
      end
    end
    if (go) begin
      v <= value;
      r <= '0;
      b <= 34'h1_0000_0000;
    end else if (cnt != '0) begin
      if (v >= trial) begin
        v <= v - trial;
        r <= (r >> 1) + b;
      end else begin
        r <= r >> 1;
      end
      b <= b >> 2;
    end
  end

  property p_done_after_run;
    @(posedge clk) disable iff (rst) done |-> $past(cnt) == 5'd1;
  endproperty
  a_done_after_run: assert property (p_done_after_run) else $error("root done out of step");

  property p_go_loads;
    @(posedge clk) disable iff (rst) go |=> cnt == 5'(RootSteps);
  endproperty
  a_go_loads: assert property (p_go_loads) else $error("root start not loaded");

  property p_b_shrinks;
    @(posedge clk) disable iff (rst) (cnt != '0 && !go) |=> $onehot0(b);
  endproperty
  a_b_shrinks: assert property (p_b_shrinks) else $error("root bit mask broken");

endmodule

[src/nearest_segment_ray_hit_top.sv]
// Top level: segment table, cross-product front end, divider cell chain, nearest-hit select, square root.
//
//  channel   | handshake              | payload
//  ----------+------------------------+------------------------------
//  command   | start / busy           | command (nsrh_pkg::command_t)
//  result    | done (strobe)          | result  (nsrh_pkg::result_t)
//  config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A segment write goes straight into the table and leaves busy low.
// A cast with n searched slots raises done once all n segments have left the pipe,
// directly on a miss, and after the square root of the best distance on a hit.
// With n = 0 done follows with no segment issued. One segment enters the pipe per cycle,
// and the divider chain has 17 cells.
// busy holds through the done cycle; config is refused while busy or start is high.
// Reset is synchronous; the segment table is not cleared. Results cannot be stalled.
module nearest_segment_ray_hit_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  nsrh_pkg::command_t                  command,
  output logic                                done,
  output nsrh_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nsrh_pkg::CfgIndexW-1:0]      cfg_index,
  input  logic [nsrh_pkg::CfgDataW-1:0]       cfg_data
);
  import nsrh_pkg::*;

  state_t state, state_next;

  logic [15:0]       range_limit;
  logic [CountW-1:0] segment_count;
  segment_t          table_q [MaxSegments];

  logic signed [15:0] p0x, p0y;
  logic signed [16:0] s10x, s10y;
  logic [CountW-1:0]  n, k, fin;
  logic [33:0]        best;
  logic               hit;
  logic signed [15:0] bx, by;
  logic [15:0]        near_dist;

  logic accept, issue, sq_go, sq_done;
  logic [17:0] sq_root;

  assign cfg_ready = !busy && !start;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_limit   <= 16'd1280;
      segment_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RANGE_LIMIT:   range_limit   <= cfg_data;
        CFG_SEGMENT_COUNT: segment_count <= cfg_data[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && command.operation == OP_WRITE) begin
      table_q[command.slot] <= {command.start_x, command.start_y, command.end_x, command.end_y};
    end
  end

  // ---------------- front end ----------------
  logic               e1_v, e2_v, e3_v;
  logic signed [16:0] s32x, s32y, s02x, s02y;
  logic signed [33:0] m1, m2, m3, m4, m5, m6;
  logic signed [34:0] denom, sn, tn;
  segment_t           seg;
  logic               pos, pass_c;
  div_lane_t          lanes [DivSteps+1];

  assign seg = table_q[k[SlotW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_v <= 1'b0;
      e2_v <= 1'b0;
      e3_v <= 1'b0;
    end else begin
      e1_v <= issue;
      e2_v <= e1_v;
      e3_v <= e2_v;
    end
    s32x  <= 17'(seg.x2) - 17'(seg.x1);
    s32y  <= 17'(seg.y2) - 17'(seg.y1);
    s02x  <= 17'(p0x) - 17'(seg.x1);
    s02y  <= 17'(p0y) - 17'(seg.y1);
    m1    <= s10x * s32y;
    m2    <= s32x * s10y;
    m3    <= s10x * s02y;
    m4    <= s10y * s02x;
    m5    <= s32x * s02y;
    m6    <= s32y * s02x;
    denom <= 35'(m1) - 35'(m2);
    sn    <= 35'(m3) - 35'(m4);
    tn    <= 35'(m5) - 35'(m6);
  end

  // sign and range tests follow denom's sign exactly, ends included differently per sign
  always_comb begin
    pos    = denom > 35'sd0;
    pass_c = !(denom > -CollinearEps && denom < CollinearEps);
    if ((sn < 35'sd0) == pos) pass_c = 1'b0;
    if ((tn < 35'sd0) == pos) pass_c = 1'b0;
    if (((sn > denom) == pos) || ((tn > denom) == pos)) pass_c = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lanes[0].valid <= 1'b0;
    end else begin
      lanes[0].valid <= e3_v;
    end
    lanes[0].pass <= pass_c;
    lanes[0].rem  <= {1'b0, (tn < 35'sd0) ? MagW'(-tn) : MagW'(tn)};
    lanes[0].ad   <= (denom < 35'sd0) ? MagW'(-denom) : MagW'(denom);
    lanes[0].q    <= '0;
  end

  // ---------------- divider chain ----------------
  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    nsrh_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .lane_in  (lanes[i]),
      .lane_out (lanes[i+1])
    );
  end

  // ---------------- back end ----------------
  logic               e5_v, e6_v, e7_v;
  logic               e5_p, e6_p, e7_p;
  logic signed [34:0] px, py, rx, ry;
  logic signed [18:0] dx, dy;
  logic signed [15:0] ix6, iy6, ix7, iy7;
  logic signed [37:0] pxx, pyy;
  logic [33:0]        sqx, sqy, sq;

  assign rx  = px + 35'sd32768;
  assign ry  = py + 35'sd32768;
  assign pxx = dx * dx;
  assign pyy = dy * dy;
  assign sq  = sqx + sqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      e5_v <= 1'b0;
      e6_v <= 1'b0;
      e7_v <= 1'b0;
    end else begin
      e5_v <= lanes[DivSteps].valid;
      e6_v <= e5_v;
      e7_v <= e6_v;
    end
    e5_p <= lanes[DivSteps].pass;
    e6_p <= e5_p;
    e7_p <= e6_p;
    px   <= $signed({1'b0, lanes[DivSteps].q}) * s10x;
    py   <= $signed({1'b0, lanes[DivSteps].q}) * s10y;
    // floor shift with round half up
    dx   <= rx[34:16];
    dy   <= ry[34:16];
    ix6  <= p0x + rx[31:16];
    iy6  <= p0y + ry[31:16];
    sqx  <= pxx[33:0];
    sqy  <= pyy[33:0];
    ix7  <= ix6;
    iy7  <= iy6;
  end

  // ---------------- cast bookkeeping ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      k   <= '0;
      fin <= '0;
      hit <= 1'b0;
    end else if (accept && command.operation == OP_CAST) begin
      k   <= '0;
      fin <= '0;
      hit <= 1'b0;
    end else begin
      if (issue) k <= k + 1'b1;
      if (e7_v) begin
        fin <= fin + 1'b1;
        if (e7_p && sq < best) hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && command.operation == OP_CAST) begin
      p0x  <= command.start_x;
      p0y  <= command.start_y;
      s10x <= 17'(command.end_x) - 17'(command.start_x);
      s10y <= 17'(command.end_y) - 17'(command.start_y);
      n    <= (segment_count > CountW'(MaxSegments)) ? CountW'(MaxSegments) : segment_count;
      best <= 34'(range_limit) * 34'(range_limit);
      bx   <= command.end_x;
      by   <= command.end_y;
    end else if (e7_v && e7_p && sq < best) begin
      best <= sq;
      bx   <= ix7;
      by   <= iy7;
    end
    if (state == ST_SCAN && fin == n && !hit) begin
      near_dist <= range_limit;
    end else if (sq_done) begin
      near_dist <= (sq_root > 18'd65535) ? 16'hFFFF : sq_root[15:0];
    end
  end

  nsrh_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .go    (sq_go),
    .value (best),
    .done  (sq_done),
    .root  (sq_root)
  );

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept && command.operation == OP_CAST) state_next = ST_SCAN;
      ST_SCAN: if (fin == n) state_next = hit ? ST_ROOT : ST_EMIT;
      ST_ROOT: if (sq_done) state_next = ST_EMIT;
      ST_EMIT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = (state != ST_IDLE);
    done  = (state == ST_EMIT);
    issue = (state == ST_SCAN) && (k < n);
    sq_go = (state == ST_SCAN) && (fin == n) && hit;
  end

  assign result.hit      = hit;
  assign result.distance = near_dist;
  assign result.point_x  = bx;
  assign result.point_y  = by;

  property p_fin_bounded;
    @(posedge clk) disable iff (rst) state == ST_SCAN |-> (fin <= k && k <= n);
  endproperty
  a_fin_bounded: assert property (p_fin_bounded) else $error("more segments retired than issued");

  property p_root_in_state;
    @(posedge clk) disable iff (rst) sq_done |-> state == ST_ROOT;
  endproperty
  a_root_in_state: assert property (p_root_in_state) else $error("root done outside root phase");

  property p_miss_distance;
    @(posedge clk) disable iff (rst) (done && !result.hit) |-> result.distance == range_limit;
  endproperty
  a_miss_distance: assert property (p_miss_distance) else $error("miss without range limit");

  property p_done_one_cycle;
    @(posedge clk) disable iff (rst) done |=> !done;
  endproperty
  a_done_one_cycle: assert property (p_done_one_cycle) else $error("result strobe too long");

endmodule
